// ----- sv/ffha_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
// No dependencies; imported by first_fit_heap_allocator and the testbench.
package ffha_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned REQ_BYTES_W   = 15;
  localparam int unsigned REQ_BYTES_MAX = 32767;
  localparam int unsigned HEAP_GRAN_W   = 13;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [ADDR_W-1:0]      HEAP_BASE_RESET = 32'd1;
  localparam logic [HEAP_GRAN_W-1:0] HEAP_GRAN_RESET = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_GRANULES = 1'b1;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ALLOC,
    ST_FHDR,
    ST_FWALK,
    ST_SPLIT,
    ST_RESP
  } state_e;

endpackage

// ----- sv/ffha_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ffha_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ffha_div.sv -----
// Divider by a power-of-two constant: shift and mask, registered the cycle after start.
// Depends on nothing; used by first_fit_heap_allocator for granule math.
module ffha_div #(
  parameter int unsigned DIVISOR = 8,
  parameter int unsigned WIDTH   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [WIDTH-1:0]           dividend_i,
  output logic                       done_o,
  output logic [WIDTH-1:0]           quotient_o,
  output logic [$clog2(DIVISOR)-1:0] remainder_o
);

  localparam int unsigned RW = $clog2(DIVISOR);

  logic [WIDTH-1:0] quo_q;
  logic [RW-1:0]    rem_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i >> RW;
      rem_q <= dividend_i[RW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// First-fit heap allocator with block splitting and forward coalescing.
// After acceptance: granule division, then header reads (the walk on an allocate; the
// freed header and each header checked for merging on a free), a split or tail header
// write where needed, then the load of the output register. One item at a time; the
// next is accepted the cycle after that load, held off while a reply stalls.
// Reset: base 1, 4096 granules; the RAM is swept clear while no item is accepted.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_DEPTH    = 4096,
  parameter int unsigned GRANULE_BYTES = 8      // power of two
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ffha_pkg::ADDR_W-1:0]      cfg_data_i,
  // request
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             action_i,
  input  logic [ffha_pkg::REQ_BYTES_W-1:0] request_bytes_i,
  input  logic [ffha_pkg::ADDR_W-1:0]      block_address_i,
  // response
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             granted_o,
  output logic [ffha_pkg::ADDR_W-1:0]      payload_address_o
);

  import ffha_pkg::*;

  localparam int unsigned AW     = $clog2(HEAP_DEPTH);
  localparam int unsigned LW     = $clog2(HEAP_DEPTH + 1);  // limit and block sizes
  localparam int unsigned PW     = LW + 1;                  // walk positions
  localparam int unsigned NEED_W = $clog2(REQ_BYTES_MAX / GRANULE_BYTES + 3);
  localparam int unsigned CW     = ((NEED_W > PW) ? NEED_W : PW) + 1;
  localparam int unsigned LCMP_W = (LW > HEAP_GRAN_W) ? LW : HEAP_GRAN_W;
  localparam int unsigned RW     = $clog2(GRANULE_BYTES);
  localparam int unsigned MW     = LW + 1;

  typedef struct packed {
    logic          used;
    logic [LW-1:0] size;
  } hdr_t;

  // configuration registers
  logic [ADDR_W-1:0]      heap_base_q;
  logic [HEAP_GRAN_W-1:0] heap_granules_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q     <= HEAP_BASE_RESET;
      heap_granules_q <= HEAP_GRAN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEAP_BASE:     heap_base_q     <= cfg_data_i;
        CFG_HEAP_GRANULES: heap_granules_q <= cfg_data_i[HEAP_GRAN_W-1:0];
        default:           ;
      endcase
    end
  end

  logic [LW-1:0] limit_c;
  assign limit_c = (LCMP_W'(heap_granules_q) < LCMP_W'(HEAP_DEPTH)) ?
                   LW'(heap_granules_q) : LW'(HEAP_DEPTH);

  // header RAM
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  hdr_t          mem_wdata, rd;
  logic [MW-1:0] mem_rdata;

  ffha_ram #(
    .WIDTH (MW),
    .DEPTH (HEAP_DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd = hdr_t'(mem_rdata);

  // granule divider
  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  logic              div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [RW-1:0]     div_rem;

  ffha_div #(
    .DIVISOR (GRANULE_BYTES),
    .WIDTH   (ADDR_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // control state
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              act_q, act_d;
  logic [LW-1:0]     limit_q, limit_d;
  logic [PW-1:0]     g_q, g_d;       // alloc walk position, or header being freed
  logic [PW-1:0]     p_q, p_d;       // coalescing position
  logic [LW-1:0]     sum_q, sum_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [PW-1:0]     sec_addr_q, sec_addr_d;
  hdr_t              sec_data_q, sec_data_d;
  logic              res_gnt_q, res_gnt_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic              out_valid_q, out_gnt_q, out_load;
  logic [ADDR_W-1:0] out_addr_q;

  logic              in_fire;
  logic [CW-1:0]     sz_c, need_c, g_c, lim_c, p_c, tail_c;
  logic [PW-1:0]     g_next, p_next;
  logic [PW:0]       sum_next;
  logic [ADDR_W-1:0] grant_addr;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign sz_c     = CW'(rd.size);
  assign need_c   = CW'(need_q);
  assign g_c      = CW'(g_q);
  assign p_c      = CW'(p_q);
  assign lim_c    = CW'(limit_q);
  assign tail_c   = g_c + need_c;
  assign g_next   = g_q + PW'(rd.size);
  assign p_next   = p_q + PW'(rd.size);
  assign sum_next = (PW+1)'(sum_q) + (PW+1)'(rd.size);
  assign grant_addr = heap_base_q +
                      ((ADDR_W'(g_q) + ADDR_W'(1)) * ADDR_W'(GRANULE_BYTES));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    act_d        = act_q;
    limit_d      = limit_q;
    g_d          = g_q;
    p_d          = p_q;
    sum_d        = sum_q;
    need_d       = need_q;
    sec_addr_d   = sec_addr_q;
    sec_data_d   = sec_data_q;
    res_gnt_d    = res_gnt_q;
    res_addr_d   = res_addr_q;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = g_q[AW-1:0];
    mem_wdata    = '0;
    mem_raddr    = g_q[AW-1:0];
    div_start    = 1'b0;
    div_dividend = (action_i == ACT_FREE) ? (block_address_i - heap_base_q)
                                          : ADDR_W'(request_bytes_i);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(HEAP_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          div_start  = 1'b1;
          act_d      = action_i;
          limit_d    = limit_c;
          res_gnt_d  = 1'b0;
          res_addr_d = '0;
          state_d    = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          if (act_q == ACT_ALLOC) begin
            // header granule plus payload rounded up
            need_d = NEED_W'(div_quo) + NEED_W'(1) + NEED_W'(div_rem != '0);
            g_d    = '0;
            mem_raddr = '0;
            state_d   = (limit_q == '0) ? ST_RESP : ST_ALLOC;
          end else if (div_rem != '0 || div_quo == '0 ||
                       div_quo > ADDR_W'(limit_q)) begin
            state_d = ST_RESP;
          end else begin
            g_d       = PW'(div_quo - ADDR_W'(1));
            mem_raddr = AW'(div_quo - ADDR_W'(1));
            state_d   = ST_FHDR;
          end
        end
      end

      ST_ALLOC: begin
        if (rd.used && rd.size == '0) begin
          state_d = ST_RESP;
        end else if (!rd.used && rd.size == '0) begin
          // untouched tail
          if (need_c > lim_c - g_c) begin
            state_d = ST_RESP;
          end else begin
            mem_we     = 1'b1;
            mem_wdata  = '{used: 1'b1, size: LW'(need_q)};
            res_gnt_d  = 1'b1;
            res_addr_d = grant_addr;
            sec_addr_d = PW'(tail_c);
            sec_data_d = '0;
            state_d    = (tail_c < lim_c) ? ST_SPLIT : ST_RESP;
          end
        end else if (!rd.used && sz_c >= need_c) begin
          mem_we     = 1'b1;
          mem_wdata  = '{used: 1'b1, size: LW'(need_q)};
          res_gnt_d  = 1'b1;
          res_addr_d = grant_addr;
          sec_addr_d = PW'(tail_c);
          sec_data_d = '{used: 1'b0, size: LW'(sz_c - need_c)};
          state_d    = (sz_c > need_c && tail_c < lim_c) ? ST_SPLIT : ST_RESP;
        end else begin
          g_d       = g_next;
          mem_raddr = g_next[AW-1:0];
          if (CW'(g_next) >= lim_c) begin
            state_d = ST_RESP;
          end
        end
      end

      ST_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = sec_addr_q[AW-1:0];
        mem_wdata = sec_data_q;
        state_d   = ST_RESP;
      end

      ST_FHDR: begin
        if (!rd.used || rd.size == '0) begin
          state_d = ST_RESP;   // double free or bad header
        end else begin
          sum_d     = rd.size;
          p_d       = g_next;
          mem_raddr = g_next[AW-1:0];
          res_gnt_d = 1'b1;
          if (CW'(g_next) < lim_c) begin
            state_d = ST_FWALK;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = '{used: 1'b0, size: rd.size};
            state_d   = ST_RESP;
          end
        end
      end

      ST_FWALK: begin
        if (!rd.used && rd.size != '0 && sz_c <= lim_c - p_c) begin
          sum_d     = LW'(sum_next);
          p_d       = p_next;
          mem_raddr = p_next[AW-1:0];
          if (CW'(p_next) >= lim_c) begin
            mem_we    = 1'b1;
            mem_wdata = '{used: 1'b0, size: LW'(sum_next)};
            state_d   = ST_RESP;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = '{used: 1'b0, size: sum_q};
          state_d   = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    limit_q    <= limit_d;
    g_q        <= g_d;
    p_q        <= p_d;
    sum_q      <= sum_d;
    need_q     <= need_d;
    sec_addr_q <= sec_addr_d;
    sec_data_q <= sec_data_d;
    res_gnt_q  <= res_gnt_d;
    res_addr_q <= res_addr_d;
    if (out_load) begin
      out_gnt_q  <= res_gnt_q;
      out_addr_q <= res_addr_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_o         = out_gnt_q;
  assign payload_address_o = out_addr_q;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for first_fit_heap_allocator: directed and random allocate/free beats.
// Depends on ffha_pkg and the allocator RTL. The heap_mirror class predicts each reply.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  localparam int unsigned HEAP_DEPTH    = 4096;
  localparam int unsigned GRANULE_BYTES = 8;
  localparam int unsigned MAX_CYCLES    = 25_000_000;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned NUM_PHASES    = 9;

  typedef struct packed {
    logic              granted;
    logic [ADDR_W-1:0] payload_address;
  } reply_t;

  typedef struct {
    logic [ADDR_W-1:0] base;
    int unsigned       granules;
    int unsigned       items;
  } phase_t;

  // Mirror of the header store and registers; predicts one reply per accepted request.
  class heap_mirror;
    logic [ADDR_W-1:0]      base;
    logic [HEAP_GRAN_W-1:0] granules;
    bit                     used [HEAP_DEPTH];
    logic [HEAP_GRAN_W-1:0] size_of [HEAP_DEPTH];
    logic [ADDR_W-1:0]      last_freed;
    reply_t                 replies_due [$];
    int unsigned            errors;
    int unsigned            grants;
    int unsigned            refusals;

    function new();
      base       = HEAP_BASE_RESET;
      granules   = HEAP_GRAN_RESET;
      last_freed = HEAP_BASE_RESET;
      errors     = 0;
      grants     = 0;
      refusals   = 0;
      foreach (used[i]) begin
        used[i]    = 1'b0;
        size_of[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      if (idx == CFG_HEAP_BASE) base = data;
      else if (idx == CFG_HEAP_GRANULES) granules = data[HEAP_GRAN_W-1:0];
    endfunction

    function int unsigned limit();
      return (granules < HEAP_DEPTH) ? int'(granules) : HEAP_DEPTH;
    endfunction

    function logic [ADDR_W-1:0] header_addr(int unsigned g);
      return base + ADDR_W'((g + 1) * GRANULE_BYTES);
    endfunction

    function void mark(int unsigned g, int unsigned lim, bit busy, int unsigned sz);
      if (g < lim) begin
        used[g]    = busy;
        size_of[g] = HEAP_GRAN_W'(sz);
      end
    endfunction

    function bit take_space(logic [REQ_BYTES_W-1:0] bytes, output logic [ADDR_W-1:0] where);
      int unsigned lim, need, g, sz;
      lim   = limit();
      need  = bytes / GRANULE_BYTES + 1 + (((bytes % GRANULE_BYTES) != 0) ? 1 : 0);
      where = '0;
      g     = 0;
      while (g < lim) begin
        sz = 32'(size_of[g]);
        if (used[g]) begin
          if (sz == 0) return 1'b0;
        end else if (sz == 0) begin
          // untouched tail: block must end inside the region
          if (need > lim - g) return 1'b0;
          mark(g, lim, 1'b1, need);
          mark(g + need, lim, 1'b0, 0);
          where = header_addr(g);
          return 1'b1;
        end else if (sz >= need) begin
          mark(g, lim, 1'b1, need);
          if (sz > need) mark(g + need, lim, 1'b0, sz - need);
          where = header_addr(g);
          return 1'b1;
        end
        g += sz;
      end
      return 1'b0;
    endfunction

    function bit release_block(logic [ADDR_W-1:0] where);
      logic [ADDR_W-1:0] offset;
      int unsigned       lim, idx, h, total, p;
      lim    = limit();
      offset = where - base;
      if ((offset % GRANULE_BYTES) != 0) return 1'b0;
      idx = offset / GRANULE_BYTES;
      if (idx == 0 || idx > lim) return 1'b0;
      h = idx - 1;
      if (!used[h] || size_of[h] == 0) return 1'b0;
      used[h] = 1'b0;
      total   = 32'(size_of[h]);
      p       = h + total;
      // absorb following free blocks that stay inside the region
      while (p < lim && !used[p] && size_of[p] != 0 && 32'(size_of[p]) <= lim - p) begin
        total += 32'(size_of[p]);
        p     += 32'(size_of[p]);
      end
      size_of[h] = HEAP_GRAN_W'(total);
      last_freed = where;
      return 1'b1;
    endfunction

    // payload address of some live block inside the region, if any
    function bit pick_busy(output logic [ADDR_W-1:0] where);
      int unsigned lim, start, h;
      lim   = limit();
      where = '0;
      if (lim == 0) return 1'b0;
      start = $urandom_range(0, lim - 1);
      for (int unsigned k = 0; k < lim; k++) begin
        h = (start + k) % lim;
        if (used[h] && size_of[h] != 0) begin
          where = header_addr(h);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic act, logic [REQ_BYTES_W-1:0] bytes,
                               logic [ADDR_W-1:0] where);
      reply_t            due;
      logic [ADDR_W-1:0] got;
      got = '0;
      if (act == ACT_ALLOC) due.granted = take_space(bytes, got);
      else due.granted = release_block(where);
      due.payload_address = (due.granted && act == ACT_ALLOC) ? got : '0;
      if (due.granted) grants++;
      else refusals++;
      replies_due.push_back(due);
    endfunction

    function void check_reply(logic granted, logic [ADDR_W-1:0] payload);
      reply_t due;
      if (replies_due.size() == 0) begin
        $error("reply beat with nothing outstanding: granted %0b payload_address %h",
               granted, payload);
        errors++;
        return;
      end
      due = replies_due.pop_front();
      if (granted !== due.granted) begin
        $error("granted: expected %0b, actual %0b", due.granted, granted);
        errors++;
      end
      if (payload !== due.payload_address) begin
        $error("payload_address: expected %h, actual %h", due.payload_address, payload);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [ADDR_W-1:0]      cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   action_i;
  logic [REQ_BYTES_W-1:0] request_bytes_i;
  logic [ADDR_W-1:0]      block_address_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   granted_o;
  logic [ADDR_W-1:0]      payload_address_o;

  heap_mirror  mirror;
  int unsigned cycles = 0;

  first_fit_heap_allocator #(
    .HEAP_DEPTH   (HEAP_DEPTH),
    .GRANULE_BYTES(GRANULE_BYTES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .request_bytes_i  (request_bytes_i),
    .block_address_i  (block_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_o        (granted_o),
    .payload_address_o(payload_address_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Leaves valid high on return so back-to-back beats never drop it.
  task automatic send_request(input logic act, input logic [REQ_BYTES_W-1:0] bytes,
                              input logic [ADDR_W-1:0] where, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    request_bytes_i <= bytes;
    block_address_i <= where;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(act, bytes, where);
  endtask

  task automatic take_reply(input bit no_stall);
    int unsigned hold;
    hold = no_stall ? 0 : $urandom_range(0, 14);
    if (hold != 0) begin
      out_stall_i <= 1'b1;
      if ($urandom_range(0, 1) == 1) begin
        // keep the beat waiting once it shows up
        do @(posedge clk_i); while (!out_valid_o);
        hold--;
      end
      repeat (hold) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
    do @(posedge clk_i); while (!out_valid_o);
    mirror.check_reply(granted_o, payload_address_o);
  endtask

  // Only called with nothing outstanding and in_valid_i low.
  task automatic configure_heap(input logic [ADDR_W-1:0] new_base,
                                input int unsigned new_granules);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_HEAP_BASE;
    cfg_data_i  <= new_base;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.write_reg(CFG_HEAP_BASE, new_base);
    cfg_index_i <= CFG_HEAP_GRANULES;
    cfg_data_i  <= ADDR_W'(new_granules);
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.write_reg(CFG_HEAP_GRANULES, ADDR_W'(new_granules));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : reply_side
    int unsigned reply_no;
    reply_no = 0;
    @(posedge rst_ni);
    forever begin
      take_reply((reply_no % 50) < 10);
      reply_no++;
    end
  end

  initial begin : stimulus
    phase_t                 plan [NUM_PHASES];
    int unsigned            sent, lim, max_b, r;
    logic                   act;
    logic [REQ_BYTES_W-1:0] bytes;
    logic [ADDR_W-1:0]      where;

    mirror          = new();
    sent            = 0;
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_HEAP_BASE;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_ALLOC;
    request_bytes_i <= '0;
    block_address_i <= '0;
    out_stall_i     <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset settings: base 1, full 4096-granule region
    send_request(ACT_ALLOC, 15'd0, $urandom(), 1'b0);      // one-granule block
    send_request(ACT_ALLOC, 15'd1, $urandom(), 1'b0);
    send_request(ACT_ALLOC, 15'd8, $urandom(), 1'b0);
    send_request(ACT_ALLOC, 15'd32767, $urandom(), 1'b0);  // larger than the region
    send_request(ACT_ALLOC, 15'd100, $urandom(), 1'b0);
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(3), 1'b0);
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(3), 1'b0);  // double
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(3) + 3, 1'b0);
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.base, 1'b0);
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(HEAP_DEPTH), 1'b0);
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(19), 1'b0);  // tail
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(1), 1'b0);   // merges
    send_request(ACT_ALLOC, 15'd16, $urandom(), 1'b0);     // split leaves one granule
    send_request(ACT_ALLOC, 15'd0, $urandom(), 1'b0);      // exact fit
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(5), 1'b0);
    send_request(ACT_ALLOC, 15'd32760, $urandom(), 1'b0);
    send_request(ACT_ALLOC, 15'd16384, $urandom(), 1'b0);
    send_request(ACT_ALLOC, 15'd16384, $urandom(), 1'b0);
    send_request(ACT_ALLOC, 15'd16216, $urandom(), 1'b0);  // fills to the region end
    send_request(ACT_ALLOC, 15'd120, $urandom(), 1'b0);    // walk runs off the end
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), 32'hFFFF_FFFF, 1'b0);
    send_request(ACT_FREE, REQ_BYTES_W'($urandom()), mirror.header_addr(2068), 1'b0);
    in_valid_i <= 1'b0;
    sent = 22;

    plan[0] = '{base: 32'hFFFF_FFFF, granules: 4096, items: 150};
    plan[1] = '{base: $urandom(), granules: 24, items: 150};
    plan[2] = '{base: $urandom(), granules: 0, items: 40};
    plan[3] = '{base: $urandom(), granules: 1, items: 40};
    plan[4] = '{base: 32'd1, granules: 300, items: 200};
    plan[5] = '{base: $urandom(), granules: 4096, items: 150};
    plan[6] = '{base: $urandom(), granules: $urandom_range(2, 200), items: 200};
    plan[7] = '{base: $urandom(), granules: 4095, items: 150};
    plan[8] = '{base: $urandom(), granules: 16, items: 120};

    foreach (plan[ph]) begin
      while (mirror.replies_due.size() != 0) @(posedge clk_i);
      configure_heap(plan[ph].base, plan[ph].granules);
      for (int unsigned n = 0; n < plan[ph].items; n++) begin
        lim   = mirror.limit();
        max_b = (lim * GRANULE_BYTES) / 6;
        if (max_b > REQ_BYTES_MAX) max_b = REQ_BYTES_MAX;
        act   = ACT_FREE;
        bytes = REQ_BYTES_W'($urandom());
        where = $urandom();
        r     = $urandom_range(0, 99);
        if (r < 50) begin
          act   = ACT_ALLOC;
          bytes = REQ_BYTES_W'($urandom_range(0, max_b));
        end else if (r < 85) begin
          if (!mirror.pick_busy(where)) where = $urandom();
        end else if (r < 90) begin
          where = mirror.last_freed;
        end else if (r < 95) begin
          r = $urandom_range(0, 2);
          if (r == 0) begin
            where = mirror.header_addr($urandom_range(0, HEAP_DEPTH - 1)) +
                    $urandom_range(1, GRANULE_BYTES - 1);
          end else if (r == 1) begin
            where = mirror.header_addr(lim + $urandom_range(0, 3));
          end else begin
            where = mirror.base;
          end
        end else begin
          act   = ACT_ALLOC;
          bytes = REQ_BYTES_W'($urandom_range(0, REQ_BYTES_MAX));
        end
        send_request(act, bytes, where, (n % 64) < 12);
        sent++;
      end
      in_valid_i <= 1'b0;
    end

    while (mirror.replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests over %0d heap settings: %0d granted, %0d refused, %0d errors",
             sent, NUM_PHASES + 1, mirror.grants, mirror.refusals, mirror.errors);
    if (mirror.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/ffha_div.sv
sv/first_fit_heap_allocator.sv
test/testbench.sv
